// ----- src/bfga_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfga_pkg: shared types and constants of the glyph blit addresser
// Action codes, register indexes, reset values and the command and status
// words that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfga_pkg;

  // Map depth
  localparam int unsigned MAP_ENTRIES = 256;

  // Field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned GLYPH_W  = 8;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned CWID_W   = 8;
  localparam int unsigned SHEET_W  = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BEGIN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEXT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_COLS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_ROWS  = 2'd3;

  // Register reset values
  localparam logic [CWID_W-1:0]  RST_CHAR_WIDTH  = 8'd8;
  localparam logic [CWID_W-1:0]  RST_CHAR_HEIGHT = 8'd8;
  localparam logic [SHEET_W-1:0] RST_SHEET_COLS  = 9'd16;
  localparam logic [SHEET_W-1:0] RST_SHEET_ROWS  = 9'd16;

  // Special character codes
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_SPACE   = 8'h20;

  // Saturation limits
  localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;
  localparam logic [COORD_W-1:0] WIDTH_MAX = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // latch the input word
    logic apply;     // run a load, begin or unused action and post its result
    logic lookup;    // read the glyph map
    logic prep;      // seed the divider
    logic div_step;  // one quotient bit
    logic mul;       // register the sheet products
    logic emit;      // finish a text word and post its result
  } bfga_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
  } bfga_sts_t;

endpackage

// ----- src/bitmap_font_glyph_blit_addresser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_glyph_blit_addresser: character to glyph blit address generator
// Maps character codes to glyph sheet positions and turns a text stream into
// sheet source and screen destination pixel coordinates.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | start, busy            | action_i, char_code_i, glyph_position_i,
//           |                        | origin_x_i, origin_y_i
//  result   | done_o (one cycle)     | draw_o, src_x_o, src_y_o, dst_x_o,
//           |                        | dst_y_o, run_width_o
//  config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
//  A load, begin or unused action word passes through the apply state to done_o.
//  A text word passes through the map read, the divider seed, 8 steps of the bit-serial
//  divider (one quotient bit per cycle), the multiply stage and the result.
//  busy is high from the accept edge until the result is posted; a new word
//  may be accepted in the cycle that done_o shows the previous result.
//  Reset clears the glyph map valid bits, the cursor, the width and the
//  registers to their defaults; no clearing pass is needed.
//  The receiver cannot stall: done_o flags each result for one cycle.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_blit_addresser #(
  parameter int unsigned MapEntries = bfga_pkg::MAP_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfga_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfga_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic [bfga_pkg::ACTION_W-1:0]   action_i,
  input  logic [bfga_pkg::CODE_W-1:0]     char_code_i,
  input  logic [bfga_pkg::GLYPH_W-1:0]    glyph_position_i,
  input  logic signed [bfga_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [bfga_pkg::COORD_W-1:0] origin_y_i,
  output logic                            done_o,
  output logic                            draw_o,
  output logic [bfga_pkg::COORD_W-1:0]    src_x_o,
  output logic [bfga_pkg::COORD_W-1:0]    src_y_o,
  output logic signed [bfga_pkg::COORD_W-1:0] dst_x_o,
  output logic signed [bfga_pkg::COORD_W-1:0] dst_y_o,
  output logic [bfga_pkg::COORD_W-1:0]    run_width_o
);

  bfga_pkg::bfga_cmd_t cmd;
  bfga_pkg::bfga_sts_t sts;

  // Sequencer
  bfga_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .busy     (busy),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // Datapath
  bfga_dp #(
    .MapEntries (MapEntries)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .char_code_i      (char_code_i),
    .glyph_position_i (glyph_position_i),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .done_o           (done_o),
    .draw_o           (draw_o),
    .src_x_o          (src_x_o),
    .src_y_o          (src_y_o),
    .dst_x_o          (dst_x_o),
    .dst_y_o          (dst_y_o),
    .run_width_o      (run_width_o)
  );

endmodule

// ----- src/bfga_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfga_ctrl: sequencing controller
// Steps each accepted text word through lookup, division, multiply and result; other words go through the apply state.
// ----------------------------------------------------------------------------
module bfga_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [bfga_pkg::ACTION_W-1:0] action_i,
  output logic                          busy,
  output bfga_pkg::bfga_cmd_t           cmd_o,
  input  bfga_pkg::bfga_sts_t           sts_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_APPLY  = 3'd1;
  localparam logic [2:0] ST_LOOKUP = 3'd2;
  localparam logic [2:0] ST_PREP   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.accept   = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (action_i == bfga_pkg::ACT_TEXT) ? ST_LOOKUP : ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/bfga_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfga_dp: glyph blit datapath
// Glyph map memory, configuration registers, bit-serial divider, sheet
// multipliers, text cursor and the result register.
// ----------------------------------------------------------------------------
module bfga_dp #(
  parameter int unsigned MapEntries = bfga_pkg::MAP_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bfga_pkg::bfga_cmd_t             cmd_i,
  output bfga_pkg::bfga_sts_t             sts_o,
  input  logic                            cfg_we_i,
  input  logic [bfga_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfga_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [bfga_pkg::ACTION_W-1:0]   action_i,
  input  logic [bfga_pkg::CODE_W-1:0]     char_code_i,
  input  logic [bfga_pkg::GLYPH_W-1:0]    glyph_position_i,
  input  logic signed [bfga_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [bfga_pkg::COORD_W-1:0] origin_y_i,
  output logic                            done_o,
  output logic                            draw_o,
  output logic [bfga_pkg::COORD_W-1:0]    src_x_o,
  output logic [bfga_pkg::COORD_W-1:0]    src_y_o,
  output logic signed [bfga_pkg::COORD_W-1:0] dst_x_o,
  output logic signed [bfga_pkg::COORD_W-1:0] dst_y_o,
  output logic [bfga_pkg::COORD_W-1:0]    run_width_o
);

  localparam int unsigned AddrW = $clog2(MapEntries);
  localparam int unsigned GW    = bfga_pkg::GLYPH_W;
  localparam int unsigned CW    = bfga_pkg::COORD_W;
  localparam int unsigned WW    = bfga_pkg::CWID_W;
  localparam int unsigned SW    = bfga_pkg::SHEET_W;
  localparam int unsigned CntW  = $clog2(GW);

  // Configuration registers
  logic [WW-1:0] char_width_q, char_height_q;
  logic [SW-1:0] sheet_cols_q, sheet_rows_q;

  // Latched input word
  logic [bfga_pkg::ACTION_W-1:0] action_q;
  logic [bfga_pkg::CODE_W-1:0]   code_q;
  logic [GW-1:0]                 pos_q;
  logic [CW-1:0]                 origin_x_q, origin_y_q;

  // Glyph map
  logic [GW-1:0] map_mem [MapEntries];
  logic [MapEntries-1:0] map_vld_q;
  logic [AddrW-1:0] map_addr;
  logic [GW-1:0] rd_data_q;
  logic          hit_q;
  logic          map_wr;

  // Divider and products
  logic [GW-1:0]   glyph_q, dvd_q, quo_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic [SW-1:0]   div_shift;
  logic            div_ge;
  logic [CW-1:0]   prod_x_q, prod_y_q;

  // Text state
  logic [CW-1:0] cursor_x_q, cursor_y_q, line_start_q, width_q;
  logic [CW:0]   sum_x, sum_y, sum_w;
  logic [CW-1:0] sat_x, sat_y, sat_w;
  logic          is_newline, is_space, do_draw;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_width_q  <= bfga_pkg::RST_CHAR_WIDTH;
      char_height_q <= bfga_pkg::RST_CHAR_HEIGHT;
      sheet_cols_q  <= bfga_pkg::RST_SHEET_COLS;
      sheet_rows_q  <= bfga_pkg::RST_SHEET_ROWS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfga_pkg::REG_CHAR_WIDTH:  char_width_q  <= cfg_data_i[WW-1:0];
        bfga_pkg::REG_CHAR_HEIGHT: char_height_q <= cfg_data_i[WW-1:0];
        bfga_pkg::REG_SHEET_COLS:  sheet_cols_q  <= cfg_data_i;
        bfga_pkg::REG_SHEET_ROWS:  sheet_rows_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q   <= action_i;
      code_q     <= char_code_i;
      pos_q      <= glyph_position_i;
      origin_x_q <= origin_x_i;
      origin_y_q <= origin_y_i;
    end
  end

  // Map access: first nonzero load of an entry wins
  assign map_addr = code_q[AddrW-1:0];
  assign map_wr   = cmd_i.apply && (action_q == bfga_pkg::ACT_LOAD) &&
                    !map_vld_q[map_addr] && (pos_q != '0);

  always_ff @(posedge clk_i) begin
    if (map_wr) begin
      map_mem[map_addr] <= pos_q;
    end
    if (cmd_i.lookup) begin
      rd_data_q <= map_mem[map_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
      hit_q     <= 1'b0;
    end else begin
      if (map_wr) begin
        map_vld_q[map_addr] <= 1'b1;
      end
      if (cmd_i.lookup) begin
        hit_q <= map_vld_q[map_addr];
      end
    end
  end

  // Restoring divide, one quotient bit per step
  assign div_shift = {rem_q, dvd_q[GW-1]};
  assign div_ge    = (div_shift >= sheet_cols_q);
  assign sts_o.div_last = (cnt_q == CntW'(GW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      glyph_q <= hit_q ? rd_data_q : '0;
      dvd_q   <= hit_q ? rd_data_q : '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[GW-2:0], 1'b0};
      quo_q <= {quo_q[GW-2:0], div_ge};
      rem_q <= div_ge ? GW'(div_shift - sheet_cols_q) : div_shift[GW-1:0];
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Sheet pixel products
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_x_q <= CW'(rem_q) * CW'(char_width_q);
      prod_y_q <= CW'(quo_q) * CW'(char_height_q);
    end
  end

  // Saturating cursor and width advance
  assign sum_x = {cursor_x_q[CW-1], cursor_x_q} + {{(CW+1-WW){1'b0}}, char_width_q};
  assign sum_y = {cursor_y_q[CW-1], cursor_y_q} + {{(CW+1-WW){1'b0}}, char_height_q};
  assign sum_w = {1'b0, width_q} + {{(CW+1-WW){1'b0}}, char_width_q};
  assign sat_x = (!sum_x[CW] && sum_x[CW-1]) ? bfga_pkg::COORD_MAX : sum_x[CW-1:0];
  assign sat_y = (!sum_y[CW] && sum_y[CW-1]) ? bfga_pkg::COORD_MAX : sum_y[CW-1:0];
  assign sat_w = sum_w[CW] ? bfga_pkg::WIDTH_MAX : sum_w[CW-1:0];

  assign is_newline = (code_q == bfga_pkg::CHAR_NEWLINE);
  assign is_space   = (code_q == bfga_pkg::CHAR_SPACE);
  assign do_draw    = !is_newline && !is_space && (glyph_q != '0) &&
                      (sheet_cols_q != '0) && ({1'b0, quo_q} < sheet_rows_q);

  // Cursor and width state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q   <= '0;
      cursor_y_q   <= '0;
      line_start_q <= '0;
      width_q      <= '0;
    end else if (cmd_i.apply && (action_q == bfga_pkg::ACT_BEGIN)) begin
      cursor_x_q   <= origin_x_q;
      cursor_y_q   <= origin_y_q;
      line_start_q <= origin_x_q;
      width_q      <= '0;
    end else if (cmd_i.emit) begin
      if (is_newline) begin
        cursor_x_q <= line_start_q;
        cursor_y_q <= sat_y;
      end else begin
        cursor_x_q <= sat_x;
        width_q    <= sat_w;
      end
    end
  end

  // Result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.apply || cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      draw_o      <= 1'b0;
      src_x_o     <= '0;
      src_y_o     <= '0;
      dst_x_o     <= '0;
      dst_y_o     <= '0;
      run_width_o <= (action_q == bfga_pkg::ACT_BEGIN) ? '0 : width_q;
    end else if (cmd_i.emit) begin
      draw_o      <= do_draw;
      src_x_o     <= do_draw ? prod_x_q : '0;
      src_y_o     <= do_draw ? prod_y_q : '0;
      dst_x_o     <= do_draw ? cursor_x_q : '0;
      dst_y_o     <= do_draw ? cursor_y_q : '0;
      run_width_o <= is_newline ? width_q : sat_w;
    end
  end

endmodule
